// ----- rtl/chained_hash_table_top_assert.svh -----
// Assertion macros for the block's top file.
`ifndef CHAINED_HASH_TABLE_TOP_ASSERT_SVH
`define CHAINED_HASH_TABLE_TOP_ASSERT_SVH
// Asserts that cond implies nxt in the next cycle.
`define CHT_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
		else $error(msg);
// Asserts that cond implies prop in the same cycle.
`define CHT_ASSERT_NOW(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);
`endif

// ----- rtl/cht_pkg.sv -----
package cht_pkg;
	localparam int BUCKETS = 128;
	localparam int NODES = 1024;
	localparam int BW = $clog2(BUCKETS);
	localparam int NW = $clog2(NODES);
	localparam int LW = $clog2(NODES + 1);
	localparam int KW = 31;
	localparam int VW = 32;
	localparam int TSW = 8;
	localparam int EW = KW + VW + LW;

	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_FOUND = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_FIND = 1'b1;

	typedef struct packed {
		logic req_type;
		logic [KW-1:0] key;
		logic signed [VW-1:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic signed [VW-1:0] found_value;
	} rsp_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load_req;
		logic mod_start;
		logic head_rd;
		logic node_rd;
		logic head_wr_new;
		logic head_wr_link;
		logic node_wr;
		logic set_rsp;
		logic [1:0] rsp_status;
		logic rsp_from_head;
	} cmd_t;

	typedef struct packed {
		logic mod_done;
		logic is_find;
		logic head_valid;
		logic head_match;
		logic node_match;
		logic link_zero;
		logic pool_full;
		logic steps_done;
	} stat_t;
endpackage

// ----- rtl/cht_ram.sv -----
module cht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/cht_datapath.sv -----
module cht_datapath (
	input logic clk,
	input logic arst_n,
	input cht_pkg::cmd_t cmd,
	output cht_pkg::stat_t stat,
	input cht_pkg::req_t req,
	input logic cfg_we,
	input logic [cht_pkg::TSW-1:0] cfg_wdata,
	output cht_pkg::rsp_t rsp
);
	import cht_pkg::*;

	logic [TSW-1:0] nbuckets_q;
	req_t req_q;
	logic [KW-1:0] rem_q;
	logic [4:0] mod_cnt_q;
	logic mod_busy_q;
	logic [BW-1:0] bucket_q;
	logic [BUCKETS-1:0] hvalid_q;
	logic [LW-1:0] link_q;
	logic from_head_q;
	logic [LW-1:0] used_q;
	logic [LW-1:0] steps_q;
	logic node_pend_q;
	logic [EW-1:0] head_rdata, node_rdata, head_wdata;
	logic [KW+7:0] dsub;
	logic [TSW-1:0] div_sz;
	logic [LW-1:0] next_link, cur_link;
	logic [KW:0] shifted;
	logic [4:0] key_bit;

	// Clamp the modulus to the range one to BUCKETS.
	always_comb begin
		div_sz = nbuckets_q;
		if (div_sz == '0) div_sz = TSW'(1);
		if (32'(div_sz) > BUCKETS) div_sz = TSW'(BUCKETS);
	end

	// Restoring remainder: one key bit per cycle, MSB first.
	assign key_bit = 5'(KW-1) - mod_cnt_q;
	assign shifted = {rem_q, 1'b0} | (KW+1)'(req_q.key[key_bit]);
	assign dsub = (KW+8)'(shifted) - (KW+8)'(div_sz);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nbuckets_q <= TSW'(128);
			mod_busy_q <= 1'b0;
			mod_cnt_q <= '0;
			hvalid_q <= '0;
			used_q <= '0;
			node_pend_q <= 1'b0;
		end else begin
			if (cfg_we) nbuckets_q <= cfg_wdata;
			node_pend_q <= cmd.node_rd;
			if (cmd.mod_start) begin
				mod_busy_q <= 1'b1;
				mod_cnt_q <= '0;
			end else if (mod_busy_q) begin
				mod_cnt_q <= mod_cnt_q + 5'd1;
				if (mod_cnt_q == 5'(KW-1)) mod_busy_q <= 1'b0;
			end
			if (cmd.head_wr_new) hvalid_q[bucket_q] <= 1'b1;
			if (cmd.head_wr_link) used_q <= used_q + LW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) req_q <= req;
		if (cmd.mod_start) rem_q <= '0;
		else if (mod_busy_q) begin
			if (!dsub[KW+7]) rem_q <= KW'(dsub);
			else rem_q <= KW'(shifted);
		end
		if (mod_busy_q && mod_cnt_q == 5'(KW-1)) begin
			if (!dsub[KW+7]) bucket_q <= BW'(dsub);
			else bucket_q <= BW'(shifted);
		end
		// The first link of a chain comes straight from the head slot read.
		if (cmd.head_rd) begin
			from_head_q <= 1'b1;
			steps_q <= '0;
		end
		if (node_pend_q) begin
			link_q <= next_link;
			from_head_q <= 1'b0;
			steps_q <= steps_q + LW'(1);
		end
		if (cmd.set_rsp) begin
			rsp.status <= cmd.rsp_status;
			if (cmd.rsp_status != ST_FOUND) rsp.found_value <= '0;
			else if (cmd.rsp_from_head) rsp.found_value <= head_rdata[LW +: VW];
			else rsp.found_value <= node_rdata[LW +: VW];
		end
	end

	assign next_link = node_rdata[LW-1:0];
	assign cur_link = from_head_q ? head_rdata[LW-1:0] : link_q;

	// A new head starts an empty chain; a chained insert rewrites only the link.
	assign head_wdata = cmd.head_wr_link ? {head_rdata[EW-1:LW], used_q + LW'(1)}
		: {req_q.key, req_q.value, LW'(0)};

	cht_ram #(.WIDTH(EW), .DEPTH(BUCKETS)) u_head (
		.clk(clk), .we(cmd.head_wr_new | cmd.head_wr_link), .waddr(bucket_q),
		.wdata(head_wdata),
		.raddr(bucket_q), .rdata(head_rdata)
	);

	cht_ram #(.WIDTH(EW), .DEPTH(NODES)) u_node (
		.clk(clk), .we(cmd.node_wr), .waddr(NW'(used_q)),
		.wdata({req_q.key, req_q.value, head_rdata[LW-1:0]}),
		.raddr(NW'(cur_link - LW'(1))), .rdata(node_rdata)
	);

	assign stat.mod_done = !mod_busy_q;
	assign stat.is_find = req_q.req_type == REQ_FIND;
	assign stat.head_valid = hvalid_q[bucket_q];
	assign stat.head_match = head_rdata[EW-1 -: KW] == req_q.key;
	assign stat.node_match = node_rdata[EW-1 -: KW] == req_q.key;
	assign stat.link_zero = cur_link == '0;
	assign stat.pool_full = 32'(used_q) >= NODES;
	assign stat.steps_done = 32'(steps_q) >= NODES;
endmodule

// ----- rtl/cht_ctrl.sv -----
module cht_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	output cht_pkg::cmd_t cmd,
	input cht_pkg::stat_t stat
);
	import cht_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MOD = 3'd1;
	localparam logic [2:0] S_HEAD = 3'd2;
	localparam logic [2:0] S_EVAL = 3'd3;
	localparam logic [2:0] S_NRD = 3'd4;
	localparam logic [2:0] S_NEVAL = 3'd5;
	localparam logic [2:0] S_OUT = 3'd6;

	logic [2:0] state_q, state_d;
	logic wait_q;

	assign in_ready = state_q == S_IDLE;
	assign out_valid = state_q == S_OUT;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d = S_MOD;
				end
			end
			S_MOD: begin
				if (!wait_q) cmd.mod_start = 1'b1;
				else if (stat.mod_done) state_d = S_HEAD;
			end
			S_HEAD: begin
				cmd.head_rd = 1'b1;
				state_d = S_EVAL;
			end
			S_EVAL: begin
				cmd.set_rsp = 1'b1;
				cmd.rsp_from_head = 1'b1;
				state_d = S_OUT;
				if (!stat.is_find) begin
					if (!stat.head_valid) begin
						cmd.head_wr_new = 1'b1;
						cmd.rsp_status = ST_INSERTED;
					end else if (stat.pool_full) begin
						cmd.rsp_status = ST_FULL;
					end else begin
						cmd.node_wr = 1'b1;
						cmd.head_wr_link = 1'b1;
						cmd.rsp_status = ST_INSERTED;
					end
				end else if (!stat.head_valid) begin
					cmd.rsp_status = ST_NOT_FOUND;
				end else if (stat.head_match) begin
					cmd.rsp_status = ST_FOUND;
				end else if (stat.link_zero) begin
					cmd.rsp_status = ST_NOT_FOUND;
				end else begin
					cmd.set_rsp = 1'b0;
					cmd.node_rd = 1'b1;
					state_d = S_NEVAL;
				end
			end
			S_NRD: begin
				if (stat.link_zero || stat.steps_done) begin
					cmd.set_rsp = 1'b1;
					cmd.rsp_status = ST_NOT_FOUND;
					state_d = S_OUT;
				end else begin
					cmd.node_rd = 1'b1;
					state_d = S_NEVAL;
				end
			end
			S_NEVAL: begin
				if (stat.node_match) begin
					cmd.set_rsp = 1'b1;
					cmd.rsp_status = ST_FOUND;
					state_d = S_OUT;
				end else begin
					state_d = S_NRD;
				end
			end
			S_OUT: begin
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wait_q <= 1'b0;
		end else begin
			state_q <= state_d;
			wait_q <= state_q == S_MOD && state_d == S_MOD;
		end
	end
endmodule

// ----- rtl/chained_hash_table_top.sv -----
// Chained hash table: insert or find one item at a time.
// Input channel in_valid/in_ready carries req (req_type, key, value); the
// output channel out_valid/out_ready carries rsp (status, found_value).
// One result item per request, in request order.
// The bucket is key modulo the configured bucket count, clamped to one to 128,
// found by a bit-serial remainder unit, MSB first. The head slot is then read
// and a decision step sets the result for an insert or for a find that hits the
// head or has no chain to walk; otherwise a find walks the chain node by node.
// in_ready is high only when the block is idle; a new item is taken the cycle
// after the previous result item has been accepted.
// A stalled receiver holds the result in the output register and the block
// waits; nothing is lost.
// cfg_we writes the bucket count from cfg_wdata at once; write it only when idle.
// Reset empties all buckets and the node pool and sets the bucket count to 128.
// Bucket valid bits sit in flops; each chain's first link lives in the head RAM
// and is cleared whenever a head slot is first filled; later links live in node RAM.
module chained_hash_table_top (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input cht_pkg::req_t req,
	output logic out_valid,
	input logic out_ready,
	output cht_pkg::rsp_t rsp,
	input logic cfg_we,
	input logic [cht_pkg::TSW-1:0] cfg_wdata
);
	import cht_pkg::*;

	cmd_t cmd;
	stat_t stat;
	logic in_fire;
	logic out_miss;

	cht_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .stat(stat)
	);

	cht_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .req(req),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .rsp(rsp)
	);

	assign in_fire = in_valid && in_ready;
	assign out_miss = out_valid && rsp.status != ST_FOUND;

`include "chained_hash_table_top_assert.svh"
	`CHT_ASSERT_NEXT(a_accept_busy, clk, arst_n, in_fire, !in_ready, "busy after accept")
	`CHT_ASSERT_NOW(a_not_both, clk, arst_n, out_valid, !in_ready, "ready while result waits")
	`CHT_ASSERT_NOW(a_zero_val, clk, arst_n, out_miss, rsp.found_value == '0, "nonzero value")
endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import cht_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	req_t req = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'd0;

	chained_hash_table_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req(req),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #2 clk = ~clk;

	// Shadow copy of the table contents.
	logic [7:0] shadow_size;
	logic bkt_valid [BUCKETS];
	logic [KW-1:0] bkt_key [BUCKETS];
	logic [VW-1:0] bkt_val [BUCKETS];
	int bkt_link [BUCKETS];
	logic [KW-1:0] pool_key [NODES];
	logic [VW-1:0] pool_val [NODES];
	int pool_link [NODES];
	int pool_used;

	rsp_t pending_rsp[$];
	int errors = 0;
	bit quiet = 1'b0;
	// Keys already inserted, reused so finds hit often.
	logic [KW-1:0] known_keys[$];

	task automatic report(input string what, input int got, input int want);
		$display("error at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	function automatic rsp_t table_access(input req_t r);
		int sz;
		int b;
		int lk;
		int steps;
		rsp_t o;
		sz = int'(shadow_size);
		if (sz == 0) sz = 1;
		if (sz > BUCKETS) sz = BUCKETS;
		b = r.key % sz;
		o = '0;
		if (r.req_type == REQ_INSERT) begin
			if (!bkt_valid[b]) begin
				bkt_valid[b] = 1'b1;
				bkt_key[b] = r.key;
				bkt_val[b] = r.value;
				o.status = ST_INSERTED;
			end else if (pool_used >= NODES) begin
				o.status = ST_FULL;
			end else begin
				pool_key[pool_used] = r.key;
				pool_val[pool_used] = r.value;
				pool_link[pool_used] = bkt_link[b];
				bkt_link[b] = pool_used + 1;
				pool_used++;
				o.status = ST_INSERTED;
			end
		end else begin
			o.status = ST_NOT_FOUND;
			if (bkt_valid[b]) begin
				if (bkt_key[b] == r.key) begin
					o.status = ST_FOUND;
					o.found_value = bkt_val[b];
				end else begin
					lk = bkt_link[b];
					steps = 0;
					while (lk != 0 && steps < NODES) begin
						if (pool_key[lk-1] == r.key) begin
							o.status = ST_FOUND;
							o.found_value = pool_val[lk-1];
							break;
						end
						lk = pool_link[lk-1];
						steps++;
					end
				end
			end
		end
		return o;
	endfunction

	// Valid stays high between items that follow without a gap; drain lowers it.
	task automatic send(input logic rt, input logic [KW-1:0] k, input logic [VW-1:0] v);
		req_t r;
		r.req_type = rt;
		r.key = k;
		r.value = v;
		while (!quiet && $urandom_range(99) < 34) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_rsp.push_back(table_access(r));
		if (rt == REQ_INSERT) known_keys.push_back(k);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic set_size(input logic [7:0] s);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= s;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_size = s;
	endtask

	always @(posedge clk) begin
		if (arst_n)
			out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 34);
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_rsp.size() == 0) begin
				report("unexpected item", int'(rsp.status), 0);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.status != want.status)
					report("status", int'(rsp.status), int'(want.status));
				if (rsp.found_value != want.found_value)
					report("found_value", rsp.found_value, want.found_value);
			end
		end
	end

	function automatic logic [KW-1:0] pick_key();
		if (known_keys.size() != 0 && $urandom_range(99) < 60)
			return known_keys[$urandom_range(known_keys.size() - 1)];
		return KW'($urandom());
	endfunction

	task automatic test_extremes();
		send(REQ_FIND, 31'd0, 32'd0);
		send(REQ_INSERT, 31'd0, 32'h8000_0000);
		send(REQ_INSERT, 31'h7fff_ffff, 32'h7fff_ffff);
		send(REQ_INSERT, 31'd128, 32'hffff_ffff);
		send(REQ_INSERT, 31'd256, 32'h5555_aaaa);
		send(REQ_FIND, 31'd0, 32'hffff_ffff);
		send(REQ_FIND, 31'd128, 32'd0);
		send(REQ_FIND, 31'd256, 32'd0);
		send(REQ_FIND, 31'h7fff_ffff, 32'd0);
		send(REQ_FIND, 31'd384, 32'd0);
		send(REQ_FIND, 31'd1, 32'd0);
		// Duplicate key: the head entry wins over the newer chained one.
		send(REQ_INSERT, 31'd0, 32'd7);
		send(REQ_FIND, 31'd0, 32'd0);
	endtask

	task automatic test_sizes();
		// Zero acts as one bucket; above the bucket count clamps.
		set_size(8'd0);
		send(REQ_INSERT, 31'd12345, 32'd1);
		send(REQ_FIND, 31'd12345, 32'd0);
		set_size(8'd255);
		send(REQ_INSERT, 31'd200, 32'd2);
		send(REQ_FIND, 31'd200, 32'd0);
		// Entries stay put after a size change.
		set_size(8'd1);
		send(REQ_FIND, 31'h7fff_ffff, 32'd0);
		send(REQ_FIND, 31'd128, 32'd0);
		set_size(8'd128);
	endtask

	task automatic test_random(input int count);
		logic [7:0] sizes [6] = '{8'd1, 8'd3, 8'd17, 8'd64, 8'd127, 8'd128};
		for (int i = 0; i < count; i++) begin
			if (i % 300 == 299) set_size(sizes[$urandom_range(5)]);
			quiet = (i >= 600 && i < 750);
			if ($urandom_range(1))
				send(REQ_INSERT, pick_key(), $urandom());
			else
				send(REQ_FIND, pick_key(), $urandom());
		end
		quiet = 1'b0;
	endtask

	task automatic test_pool_full();
		// Fill the pool, then check that chained inserts report full.
		set_size(8'd2);
		while (pool_used < NODES)
			send(REQ_INSERT, pick_key(), $urandom());
		for (int i = 0; i < 40; i++)
			send(1'($urandom_range(1)), pick_key(), $urandom());
	endtask

	initial begin
		shadow_size = 8'd128;
		pool_used = 0;
		for (int i = 0; i < BUCKETS; i++) begin
			bkt_valid[i] = 1'b0;
			bkt_link[i] = 0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_sizes();
		test_random(1200);
		test_pool_full();
		drain();
		if (errors == 0)
			$display("chained_hash_table_top: match");
		else
			$display("chained_hash_table_top: mismatch");
		$finish;
	end

	initial begin
		#100ms;
		$display("chained_hash_table_top: mismatch");
		$finish;
	end
endmodule
